@@ design/utbcd_pkg.sv @@
// shared constants and helper functions for the unix time to bcd timestamp unit
package utbcd_pkg;

    // seconds per day split as 2^7 * 675, quotient by 675 through a reciprocal
    localparam int unsigned    DaySecShift   = 7;
    localparam logic [27:0]    DAY_RECIP     = 28'd203613265;
    localparam int unsigned    DayRecipShift = 37;
    localparam logic [33:0]    SECS_PER_DAY  = 34'd86400;

    // day count shifted to start at 0000-03-01, 400-year eras
    localparam logic [19:0]    EPOCH_SHIFT   = 20'd719468;
    localparam logic [19:0]    DAYS_PER_ERA  = 20'd146097;
    localparam int unsigned    MaxEra        = 6;

    // doe / 1460 as (doe >> 2) / 365
    localparam logic [16:0]    QUAD_RECIP    = 17'd91930;
    localparam int unsigned    QuadShift     = 25;
    localparam logic [17:0]    DAYS_PER_CENT = 18'd36524;
    localparam logic [17:0]    ERA_LAST_DAY  = 18'd146096;

    // t / 365 for year of era
    localparam logic [18:0]    YEAR_RECIP    = 19'd367720;
    localparam int unsigned    YearShift     = 27;

    // sod / 60 and minute-of-day / 60
    localparam logic [17:0]    SEC60_RECIP   = 18'd139811;
    localparam int unsigned    Sec60Shift    = 23;
    localparam logic [11:0]    MIN60_RECIP   = 12'd2185;
    localparam int unsigned    Min60Shift    = 17;

    // (5 * doy + 2) / 153 for the march-based month
    localparam logic [11:0]    MON_RECIP     = 12'd3427;
    localparam int unsigned    MonShift      = 19;

    localparam logic [7:0]     SIGN_PLUS     = 8'h2B;
    localparam logic [7:0]     OFFSET_ZERO   = 8'h00;

    // two-digit packed bcd of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 14'(v) * 14'd103;
        tens = prod[13:10];
        ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

    // first day of year for each march-based month, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] base;
        unique case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

@@ design/utbcd_if.sv @@
// valid/ready channel interfaces for unix seconds in and bcd timestamp out

interface utbcd_in_if;
    logic        valid;
    logic        ready;
    logic [33:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface utbcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic [7:0] sign_octet;
    logic [7:0] offset_hours_bcd;
    logic [7:0] offset_minutes_bcd;

    modport source (
        output valid, output year_bcd, output month_bcd, output day_bcd,
        output hour_bcd, output minute_bcd, output second_bcd, output sign_octet,
        output offset_hours_bcd, output offset_minutes_bcd, input ready
    );
    modport sink (
        input valid, input year_bcd, input month_bcd, input day_bcd,
        input hour_bcd, input minute_bcd, input second_bcd, input sign_octet,
        input offset_hours_bcd, input offset_minutes_bcd, output ready
    );
endinterface

@@ design/unix_time_to_bcd_timestamp_unit.sv @@
// seven-stage pipeline converting unix seconds to a bcd utc charging timestamp
// throughput: one transfer per cycle unless the output stalls; every stage is
//   a reciprocal multiply or a short compare/subtract, so the stage depth is
//   about one 28x27 multiply
// backpressure stalls all stages together; the last stage is the output register
// reset (i_rst_n low, synchronous) clears the stage valid bits only
module unix_time_to_bcd_timestamp_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utbcd_in_if.sink           i_ts,
    utbcd_out_if.source        o_ts
);
    import utbcd_pkg::*;

    // one valid bit per stage, bit 6 is the output register
    logic [6:0]  r_vld;
    logic        advance;

    // stage 1: raw seconds and the day-count product
    logic [33:0] r1_secs;
    logic [54:0] r1_prod;
    logic [54:0] n1_prod;

    // stage 2: second of day and day of era
    logic [16:0] r2_sod;
    logic [17:0] r2_doe;
    logic [17:0] s2_days;
    logic [33:0] s2_day_secs;
    logic [19:0] s2_z;
    logic [2:0]  s2_era;

    // stage 3: leap-corrected day count and minute of day
    logic [17:0] r3_t;
    logic [17:0] r3_doe;
    logic [16:0] r3_sod;
    logic [10:0] r3_tm;
    logic [32:0] s3_quad_prod;
    logic [6:0]  s3_quads;
    logic [2:0]  s3_cents;
    logic [34:0] s3_tm_prod;

    // stage 4: year product and binary time of day
    logic [36:0] r4_yprod;
    logic [17:0] r4_doe;
    logic [4:0]  r4_hour;
    logic [5:0]  r4_min;
    logic [5:0]  r4_sec;
    logic [22:0] s4_hr_prod;
    logic [4:0]  s4_hour;

    // stage 5: year of era, day of year, bcd time of day
    logic [8:0]  r5_yoe;
    logic [8:0]  r5_doy;
    logic [7:0]  r5_hour_bcd;
    logic [7:0]  r5_min_bcd;
    logic [7:0]  r5_sec_bcd;
    logic [8:0]  s5_yoe;
    logic [1:0]  s5_cents;
    logic [17:0] s5_year_days;

    // stage 6: march-based month
    logic [3:0]  r6_mp;
    logic [8:0]  r6_doy;
    logic [8:0]  r6_yoe;
    logic [7:0]  r6_hour_bcd;
    logic [7:0]  r6_min_bcd;
    logic [7:0]  r6_sec_bcd;
    logic [22:0] s6_mp_prod;

    // stage 7: output register
    logic [7:0]  r7_year_bcd;
    logic [7:0]  r7_month_bcd;
    logic [7:0]  r7_day_bcd;
    logic [7:0]  r7_hour_bcd;
    logic [7:0]  r7_min_bcd;
    logic [7:0]  r7_sec_bcd;
    logic [4:0]  s7_day;
    logic [3:0]  s7_month;
    logic [8:0]  s7_ylong;
    logic [6:0]  s7_ymod;

    // whole pipe moves when the output register is empty or being drained
    assign advance    = !r_vld[6] || o_ts.ready;
    assign i_ts.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[5:0], i_ts.valid};
        end
    end

    // ---------------- stage 1 ----------------
    // days = secs / 86400 = (secs >> 7) / 675
    assign n1_prod = 55'(i_ts.unix_seconds[33:DaySecShift]) * 55'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_secs <= i_ts.unix_seconds;
            r1_prod <= n1_prod;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        s2_days     = r1_prod[DayRecipShift +: 18];
        s2_day_secs = 34'(s2_days) * SECS_PER_DAY;
        s2_z        = 20'(s2_days) + EPOCH_SHIFT;
        // era is at most six over the input range, found by parallel compares
        s2_era = '0;
        for (int k = 1; k <= MaxEra; k++) begin
            if (s2_z >= 20'(k) * DAYS_PER_ERA) begin
                s2_era = s2_era + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_sod <= 17'(r1_secs - s2_day_secs);
            r2_doe <= 18'(s2_z - 20'(s2_era) * DAYS_PER_ERA);
        end
    end

    // ---------------- stage 3 ----------------
    always_comb begin
        // doe / 1460, at most 100
        s3_quad_prod = 33'(r2_doe[17:2]) * 33'(QUAD_RECIP);
        s3_quads     = s3_quad_prod[QuadShift +: 7];
        // doe / 36524, at most 4
        s3_cents = '0;
        for (int k = 1; k <= 4; k++) begin
            if (r2_doe >= 18'(k) * DAYS_PER_CENT) begin
                s3_cents = s3_cents + 3'd1;
            end
        end
        // minute of day
        s3_tm_prod = 35'(r2_sod) * 35'(SEC60_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            // last day of the era drops the extra leap day
            r3_t   <= r2_doe - 18'(s3_quads) + 18'(s3_cents)
                      - 18'(r2_doe == ERA_LAST_DAY);
            r3_doe <= r2_doe;
            r3_sod <= r2_sod;
            r3_tm  <= s3_tm_prod[Sec60Shift +: 11];
        end
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        s4_hr_prod = 23'(r3_tm) * 23'(MIN60_RECIP);
        s4_hour    = s4_hr_prod[Min60Shift +: 5];
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r4_yprod <= 37'(r3_t) * 37'(YEAR_RECIP);
            r4_doe   <= r3_doe;
            r4_hour  <= s4_hour;
            r4_min   <= 6'(r3_tm - 11'(s4_hour) * 11'd60);
            r4_sec   <= 6'(r3_sod - 17'(r3_tm) * 17'd60);
        end
    end

    // ---------------- stage 5 ----------------
    always_comb begin
        s5_yoe = r4_yprod[YearShift +: 9];
        // yoe / 100, at most 3
        s5_cents = '0;
        for (int k = 1; k <= 3; k++) begin
            if (s5_yoe >= 9'(k * 100)) begin
                s5_cents = s5_cents + 2'd1;
            end
        end
        s5_year_days = 18'(s5_yoe) * 18'd365 + 18'(s5_yoe[8:2]) - 18'(s5_cents);
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r5_yoe      <= s5_yoe;
            r5_doy      <= 9'(r4_doe - s5_year_days);
            r5_hour_bcd <= to_bcd(7'(r4_hour));
            r5_min_bcd  <= to_bcd(7'(r4_min));
            r5_sec_bcd  <= to_bcd(7'(r4_sec));
        end
    end

    // ---------------- stage 6 ----------------
    assign s6_mp_prod = 23'(11'(r5_doy) * 11'd5 + 11'd2) * 23'(MON_RECIP);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r6_mp       <= s6_mp_prod[MonShift +: 4];
            r6_doy      <= r5_doy;
            r6_yoe      <= r5_yoe;
            r6_hour_bcd <= r5_hour_bcd;
            r6_min_bcd  <= r5_min_bcd;
            r6_sec_bcd  <= r5_sec_bcd;
        end
    end

    // ---------------- stage 7 ----------------
    always_comb begin
        s7_day   = 5'(r6_doy - month_start(r6_mp) + 9'd1);
        s7_month = (r6_mp < 4'd10) ? r6_mp + 4'd3 : r6_mp - 4'd9;
        // january and february belong to the next civil year; eras are
        // multiples of 400 years so only year of era matters modulo 100
        s7_ylong = r6_yoe + 9'(r6_mp >= 4'd10);
        priority if (s7_ylong >= 9'd400) begin
            s7_ymod = 7'(s7_ylong - 9'd400);
        end else if (s7_ylong >= 9'd300) begin
            s7_ymod = 7'(s7_ylong - 9'd300);
        end else if (s7_ylong >= 9'd200) begin
            s7_ymod = 7'(s7_ylong - 9'd200);
        end else if (s7_ylong >= 9'd100) begin
            s7_ymod = 7'(s7_ylong - 9'd100);
        end else begin
            s7_ymod = 7'(s7_ylong);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r7_year_bcd  <= to_bcd(s7_ymod);
            r7_month_bcd <= to_bcd(7'(s7_month));
            r7_day_bcd   <= to_bcd(7'(s7_day));
            r7_hour_bcd  <= r6_hour_bcd;
            r7_min_bcd   <= r6_min_bcd;
            r7_sec_bcd   <= r6_sec_bcd;
        end
    end

    // output channel, fields truncated to their packed bcd widths
    assign o_ts.valid              = r_vld[6];
    assign o_ts.year_bcd           = r7_year_bcd;
    assign o_ts.month_bcd          = r7_month_bcd[4:0];
    assign o_ts.day_bcd            = r7_day_bcd[5:0];
    assign o_ts.hour_bcd           = r7_hour_bcd[5:0];
    assign o_ts.minute_bcd         = r7_min_bcd[6:0];
    assign o_ts.second_bcd         = r7_sec_bcd[6:0];
    assign o_ts.sign_octet         = SIGN_PLUS;
    assign o_ts.offset_hours_bcd   = OFFSET_ZERO;
    assign o_ts.offset_minutes_bcd = OFFSET_ZERO;

endmodule

@@ design/utbcd_checker.sv @@
// port-level checks for the unix time to bcd timestamp unit, with bind
module utbcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_year_bcd,
    input logic [4:0] i_month_bcd,
    input logic [5:0] i_day_bcd,
    input logic [7:0] i_sign_octet,
    input logic [7:0] i_offset_hours_bcd,
    input logic [7:0] i_offset_minutes_bcd
);
    import utbcd_pkg::*;

    // a stalled result stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_year_bcd)
        && $stable(i_month_bcd) && $stable(i_day_bcd))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");

    // input side is open whenever the output register can move
    a_in_open: assert property (@(posedge i_clk)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked with free output register");

    // fixed offset octets
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sign_octet == SIGN_PLUS && i_offset_hours_bcd == OFFSET_ZERO
        && i_offset_minutes_bcd == OFFSET_ZERO)
        else $error("offset octets wrong");

    // calendar fields are valid bcd, month and day nonzero
    a_date_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_month_bcd != 5'd0 && i_day_bcd != 6'd0
        && i_month_bcd[3:0] <= 4'd9 && i_day_bcd[3:0] <= 4'd9
        && i_year_bcd[3:0] <= 4'd9 && i_year_bcd[7:4] <= 4'd9)
        else $error("bad bcd date field");

endmodule

bind unix_time_to_bcd_timestamp_unit utbcd_checker u_utbcd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_ready           (i_ts.ready),
    .i_out_valid          (o_ts.valid),
    .i_out_ready          (o_ts.ready),
    .i_year_bcd           (o_ts.year_bcd),
    .i_month_bcd          (o_ts.month_bcd),
    .i_day_bcd            (o_ts.day_bcd),
    .i_sign_octet         (o_ts.sign_octet),
    .i_offset_hours_bcd   (o_ts.offset_hours_bcd),
    .i_offset_minutes_bcd (o_ts.offset_minutes_bcd)
);
